FILE: sv/scr_pkg.sv
// Shared types and constants for the stale channel repeater.
// No dependencies.
`default_nettype none
package scr_pkg;
   localparam int CHANNELS = 16;
   localparam int CH_W = 4;
   localparam int CNT_W = 5;

   localparam logic [1:0] ACT_RECORD = 2'd0;
   localparam logic [1:0] ACT_POLL   = 2'd1;
   localparam logic [1:0] ACT_FORGET = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] RES_ACK    = 2'd0;
   localparam logic [1:0] RES_SAMPLE = 2'd1;
   localparam logic [1:0] RES_SUMMARY = 2'd2;

   localparam logic [62:0] INTERVAL_RESET = 63'd1000000000;

   // one slot of the ring
   typedef struct packed {
      logic        valid;
      logic [63:0] activity;
      logic [63:0] value;
      logic [2:0]  kind;
   } entry_type;

   // control from top level to every cell
   typedef struct packed {
      logic             shift;     // rotate ring by one
      logic             wr;        // write head slot
      logic             clr_all;
      logic             clr_one;   // clear head slot
      logic [63:0]      now;
      logic [63:0]      value;
      logic [2:0]       kind;
   } cell_ctl_type;
endpackage
`default_nettype wire

FILE: sv/scr_cell.sv
// One slot of the rotating channel ring.
// Depends on scr_pkg.
`default_nettype none
module scr_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 is_head,
   input  wire scr_pkg::cell_ctl_type ctl,
   input  wire scr_pkg::entry_type   from_prev,
   output scr_pkg::entry_type        slot
);
   scr_pkg::entry_type slot_ff, slot_in;

   always_comb begin
      slot_in = ctl.shift ? from_prev : slot_ff;
      if (is_head && !ctl.shift) begin
         if (ctl.wr) begin
            slot_in.valid    = 1'b1;
            slot_in.activity = ctl.now;
            slot_in.value    = ctl.value;
            slot_in.kind     = ctl.kind;
         end
         if (ctl.clr_one) slot_in.valid = 1'b0;
      end
      if (ctl.clr_all) slot_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;
endmodule
`default_nettype wire

FILE: sv/stale_channel_repeater.sv
// Top level of the stale channel repeater: a ring of sixteen cells plus control.
// Depends on scr_pkg and scr_cell.
`default_nettype none
// Caches the last accepted sample per channel in a ring of CHANNELS cells that
// rotates one place a cycle while a request seeks or scans and no due channel
// holds it. Only the head cell (ring position 0) is written, but for a clear
// of all cells; a rotation pointer tracks which channel sits at the head. A
// record or forget rotates the wanted channel to the head, acts on it, then
// loads the acknowledge; clear acts in its accept cycle, and its acknowledge
// is loaded once the output register is free. A poll first rotates channel 0
// to the head, then rotates the ring once round, testing each channel at the
// head against the interval (sign test plus 64-bit magnitude, exact over 65
// bits); a due channel is emitted and restamped before the ring moves on, and
// the ring pauses there while a result waits in the output register. The
// summary follows the scan. A request is taken only when the previous one is
// finished, though its last result may still be waiting to be taken.
module stale_channel_repeater (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: channel[3:0], timestamp[67:4], value_kind[70:68],
   //        sample_value[134:71], write_accepted[135]
   input  wire logic [135:0] req_tdata,
   input  wire logic [1:0]   req_tuser,   // action
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: out_channel[3:0], out_timestamp[67:4], out_kind[70:68],
   //        out_value[134:71], reemitted_count[139:135], channel_tracked[140]
   output logic [143:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,   // result_type
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [62:0]  csr_wdata
);
   localparam int N = scr_pkg::CHANNELS;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEEK = 2'd1;
   localparam logic [1:0] ST_POLL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [62:0] interval_ff;
   logic [1:0]  state_ff, state_in;
   logic [scr_pkg::CH_W-1:0] head_ff, head_in;   // channel at the head
   logic [scr_pkg::CH_W:0]   steps_ff, steps_in; // poll rotations done
   logic [scr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]  act_ff, act_in;
   logic [3:0]  ch_ff, ch_in;
   logic [63:0] ts_ff, ts_in, val_ff, val_in;
   logic [2:0]  kind_ff, kind_in;
   logic        acc_ff, acc_in;
   logic        emitted_ff, emitted_in;   // head already emitted this visit

   logic         ov_ff, ov_in, ol_ff, ol_in, otrk_ff, otrk_in;
   logic [1:0]   otype_ff, otype_in;
   logic [3:0]   och_ff, och_in;
   logic [63:0]  ots_ff, ots_in, oval_ff, oval_in;
   logic [2:0]   okind_ff, okind_in;
   logic [4:0]   ocnt_ff, ocnt_in;

   scr_pkg::cell_ctl_type ctl;
   scr_pkg::entry_type    slots [N];

   genvar g;
   for (g = 0; g < N; g++) begin : g_ring
      scr_cell u_cell (
         .clock(clock), .reset(reset), .is_head(g == 0), .ctl(ctl),
         .from_prev(g == N-1 ? slots[0] : slots[g+1]), .slot(slots[g]));
   end

   scr_pkg::entry_type head;
   logic  free, due, older;
   logic [63:0] age;

   // age is exact once the negative case is excluded by the signed compare
   always_comb begin
      head = slots[0];
      older = $signed(ts_ff) < $signed(head.activity);
      age = ts_ff - head.activity;
      due = head.valid && !older && (age >= {1'b0, interval_ff});
   end

   assign free = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff; head_in = head_ff; steps_in = steps_ff;
      cnt_in = cnt_ff; act_in = act_ff; ch_in = ch_ff; ts_in = ts_ff;
      val_in = val_ff; kind_in = kind_ff; acc_in = acc_ff;
      emitted_in = emitted_ff;
      ov_in = ov_ff && !rsp_tready;
      otype_in = otype_ff; och_in = och_ff; ots_in = ots_ff; okind_in = okind_ff;
      oval_in = oval_ff; ocnt_in = ocnt_ff; otrk_in = otrk_ff; ol_in = ol_ff;
      ctl = '0;
      ctl.now = ts_ff; ctl.value = val_ff; ctl.kind = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               act_in = req_tuser; ch_in = req_tdata[3:0];
               ts_in = req_tdata[67:4]; kind_in = req_tdata[70:68];
               val_in = req_tdata[134:71]; acc_in = req_tdata[135];
               steps_in = '0; cnt_in = '0; emitted_in = 1'b0;
               state_in = (req_tuser == scr_pkg::ACT_POLL) ? ST_POLL :
                          (req_tuser == scr_pkg::ACT_CLEAR) ? ST_DONE : ST_SEEK;
               if (req_tuser == scr_pkg::ACT_CLEAR) ctl.clr_all = 1'b1;
            end
         end
         ST_SEEK: begin
            if (head_ff == ch_ff) begin
               ctl.wr = (act_ff == scr_pkg::ACT_RECORD) && acc_ff;
               ctl.clr_one = (act_ff == scr_pkg::ACT_FORGET);
               state_in = ST_DONE;
            end else begin
               ctl.shift = 1'b1; head_in = head_ff + 1'b1;
            end
         end
         ST_POLL: begin
            if (steps_ff == '0 && head_ff != '0) begin
               // bring channel 0 to the head so the scan runs in ascending order
               ctl.shift = 1'b1; head_in = head_ff + 1'b1;
            end else if (steps_ff == (scr_pkg::CH_W+1)'(N)) begin
               state_in = ST_DONE;
            end else if (due && !emitted_ff) begin
               if (free) begin
                  ov_in = 1'b1; otype_in = scr_pkg::RES_SAMPLE; och_in = head_ff;
                  ots_in = ts_ff; okind_in = head.kind; oval_in = head.value;
                  ocnt_in = '0; otrk_in = 1'b1; ol_in = 1'b0;
                  cnt_in = cnt_ff + 1'b1; emitted_in = 1'b1;
                  ctl.wr = 1'b1;   // restamp with same value/kind
                  ctl.value = head.value; ctl.kind = head.kind;
               end
            end else begin
               ctl.shift = 1'b1; head_in = head_ff + 1'b1;
               steps_in = steps_ff + 1'b1; emitted_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (free) begin
               ov_in = 1'b1; och_in = ch_ff; ots_in = '0; okind_in = '0;
               oval_in = '0; ol_in = 1'b1;
               otrk_in = slots[4'(ch_ff - head_ff)].valid;
               if (act_ff == scr_pkg::ACT_POLL) begin
                  otype_in = scr_pkg::RES_SUMMARY; ocnt_in = cnt_ff;
               end else begin
                  otype_in = scr_pkg::RES_ACK; ocnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; head_ff <= '0; ov_ff <= 1'b0; cnt_ff <= '0;
         interval_ff <= scr_pkg::INTERVAL_RESET;
      end else begin
         state_ff <= state_in; head_ff <= head_in; ov_ff <= ov_in; cnt_ff <= cnt_in;
         if (csr_we) interval_ff <= csr_wdata;
      end
      steps_ff <= steps_in; act_ff <= act_in; ch_ff <= ch_in;
      ts_ff <= ts_in; val_ff <= val_in; kind_ff <= kind_in; acc_ff <= acc_in;
      emitted_ff <= emitted_in;
      otype_ff <= otype_in; och_ff <= och_in; ots_ff <= ots_in;
      okind_ff <= okind_in; oval_ff <= oval_in; ocnt_ff <= ocnt_in;
      otrk_ff <= otrk_in; ol_ff <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = otype_ff;
   assign rsp_tlast  = ol_ff;
   assign rsp_tdata  = {3'b000, otrk_ff, ocnt_ff, oval_ff, okind_ff, ots_ff, och_ff};

   // requests only taken when idle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> state_ff == ST_IDLE)
      else $error("request taken while busy");
   // re-emit count never exceeds the channel count
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 5'(N)) else $error("re-emit count overflow");
   // a summary always closes a request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == scr_pkg::RES_SUMMARY) |-> rsp_tlast)
      else $error("summary without last");
endmodule
`default_nettype wire
